>>> design/signed_restoring_divider_top_assert.svh
// ----------------------------------------------------------------------------
// Signed restoring divider assertion macros
// Shared property forms for the divider's port checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_TOP_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_TOP_ASSERT_SVH

// Require a signal to keep its value in the cycle after the condition was seen.
`define SDIV_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> $stable(sig)) \
	else $error("sdiv: signal changed while it had to hold");

// Require the consequent in the same cycle as the antecedent.
`define SDIV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |-> (cons)) \
	else $error("sdiv: implication failed");

`endif

>>> design/sdiv_pkg.sv
// ----------------------------------------------------------------------------
// Signed restoring divider package
// Shared operand width for the divider, its interfaces and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdiv_pkg;

	// Default operand width
	localparam int DATA_WIDTH = 32;

endpackage

`default_nettype wire

>>> design/sdiv_if.sv
// ----------------------------------------------------------------------------
// Signed restoring divider channels
// Request channel (dividend, divisor) and response channel (quotient,
// remainder, divide-by-zero flag), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdiv_req_if #(
	parameter int W = sdiv_pkg::DATA_WIDTH
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] dividend;
	logic signed [W-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sdiv_rsp_if #(
	parameter int W = sdiv_pkg::DATA_WIDTH
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] quotient;
	logic        [W-1:0] remainder;
	logic                divide_by_zero;

	modport source (output valid, output quotient, output remainder,
		output divide_by_zero, input ready);
	modport sink   (input valid, input quotient, input remainder,
		input divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> design/signed_restoring_divider_top.sv
// ----------------------------------------------------------------------------
// Signed restoring divider
// Pipelined signed division: one restoring step per stage, operand
// magnitudes up front and the quotient sign fix at the output register.
// ----------------------------------------------------------------------------
// Path: from request acceptance to response valid a division passes the
//   magnitude stage, DATA_WIDTH step stages and the output register.
// Throughput: one division per cycle; while a response waits the whole
//   pipeline holds, input included, and no request enters.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_restoring_divider_top #(
	parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sdiv_req_if.sink    req,
	sdiv_rsp_if.source  rsp
);

	localparam int W = DATA_WIDTH;

	// Stage 0 is the magnitude stage, stage k (1..W) holds k finished steps
	logic         vld_s   [0:W];
	logic [W-1:0] rem_s   [0:W];
	logic [W-1:0] quo_s   [0:W];
	logic [W-1:0] dvs_s   [0:W];
	logic         neg_s   [0:W];
	logic         dz_s    [0:W];

	logic                out_vld_q;
	logic signed [W-1:0] out_quo_q;
	logic        [W-1:0] out_rem_q;
	logic                out_dz_q;

	logic adv;

	// Advance everything unless a response is stalled at the output
	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	// Operand signs and magnitudes
	logic         a_neg, b_neg, a_pos, b_pos;
	logic [W-1:0] a_mag, b_mag;

	always_comb begin
		a_neg = req.dividend[W-1];
		b_neg = req.divisor[W-1];
		a_pos = !a_neg && (req.dividend != '0);
		b_pos = !b_neg && (req.divisor != '0);
		a_mag = a_neg ? (~req.dividend + W'(1)) : req.dividend;
		b_mag = b_neg ? (~req.divisor + W'(1)) : req.divisor;
	end

	// Load the magnitude stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= '0;
			quo_s[0] <= a_mag;
			dvs_s[0] <= b_mag;
			neg_s[0] <= (a_neg && b_pos) || (a_pos && b_neg);
			dz_s[0]  <= (req.divisor == '0);
		end
	end

	// Restoring step stages
	for (genvar k = 1; k <= W; k++) begin : g_step
		logic         carry;
		logic [W-1:0] rem_sh;
		logic [W-1:0] quo_sh;
		logic         take;

		// Shift the pair left, trial-subtract, restore on borrow
		always_comb begin
			carry  = rem_s[k-1][W-1];
			rem_sh = {rem_s[k-1][W-2:0], quo_s[k-1][W-1]};
			quo_sh = {quo_s[k-1][W-2:0], 1'b0};
			take   = carry || (rem_sh >= dvs_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= take ? (rem_sh - dvs_s[k-1]) : rem_sh;
				quo_s[k] <= {quo_sh[W-1:1], take};
				dvs_s[k] <= dvs_s[k-1];
				neg_s[k] <= neg_s[k-1];
				dz_s[k]  <= dz_s[k-1];
			end
		end
	end

	// Output register with the quotient sign fix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_quo_q <= neg_s[W] ? (~quo_s[W] + W'(1)) : quo_s[W];
			out_rem_q <= rem_s[W];
			out_dz_q  <= dz_s[W];
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.quotient       = out_quo_q;
	assign rsp.remainder      = out_rem_q;
	assign rsp.divide_by_zero = out_dz_q;

endmodule

`default_nettype wire

>>> design/sdiv_checker.sv
// ----------------------------------------------------------------------------
// Signed restoring divider port checker
// Watches the top level's response port and binds to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "signed_restoring_divider_top_assert.svh"

module sdiv_port_checker #(
	parameter int W = sdiv_pkg::DATA_WIDTH
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         rsp_valid,
	input wire logic         rsp_ready,
	input wire logic [W-1:0] rsp_quotient,
	input wire logic [W-1:0] rsp_remainder,
	input wire logic         rsp_dz
);

	// A stalled response keeps its valid and its quotient
	`SDIV_ASSERT_HOLD(a_rsp_valid_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`SDIV_ASSERT_HOLD(a_rsp_quo_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_quotient)

	// Zero divisor gives an all-ones quotient that is never negated
	`SDIV_ASSERT_IMPL(a_dz_quotient, clk, arst_n, rsp_valid && rsp_dz, rsp_quotient == '1)

	// A real divisor keeps the remainder below the largest magnitude
	`SDIV_ASSERT_IMPL(a_rem_range, clk, arst_n, rsp_valid && !rsp_dz, !rsp_remainder[W-1])

endmodule

bind signed_restoring_divider_top sdiv_port_checker #(
	.W (DATA_WIDTH)
) u_sdiv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_quotient  (rsp.quotient),
	.rsp_remainder (rsp.remainder),
	.rsp_dz        (rsp.divide_by_zero)
);

`default_nettype wire
